// ----- rtl/gvtf_pkg.sv -----
// ----------------------------------------------------------------------------
// gvtf_pkg
// Shared types and constants of the gravity vector tracking filter: the
// sample and result words, the lane vectors, the lane operation codes and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package gvtf_pkg;

    // Width of one stored gravity component.
    localparam int G_W = 32;
    // Fraction bits of a half-angle and its total width.
    localparam int R_FRAC = 24;
    localparam int R_W = 29;
    // Configuration port widths.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam int GAIN_W = 16;
    localparam int SCALE_W = 20;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_ANGLE_SCALE = 2'd1;

    // Reset values of the registers.
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd655;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd46851;

    // One IMU sample.
    typedef struct packed {
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } sample_word_t;

    // One filter result.
    typedef struct packed {
        logic signed [G_W-1:0] gravity_x;
        logic signed [G_W-1:0] gravity_y;
        logic signed [G_W-1:0] gravity_z;
        logic                  primed;
        logic                  last_of_run;
    } result_word_t;

    // Per-axis vectors shared between the lanes.
    typedef logic signed [R_W-1:0] r_val_t;
    typedef r_val_t [2:0] r_vec_t;
    typedef logic signed [G_W-1:0] g_val_t;
    typedef g_val_t [2:0] g_vec_t;

    // Operation that every lane carries out in a cycle.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_HALF_MUL,
        OP_HALF_SUM,
        OP_CROSS_MUL,
        OP_T_SUM,
        OP_D_SUM,
        OP_CORR_MUL,
        OP_CORR_SUM,
        OP_LOAD
    } lane_op_t;

    // Lane control: the operation and whether the vector operands come from
    // the lane results instead of the stored estimate.
    typedef struct packed {
        lane_op_t op;
        logic     src_res;
    } lane_ctrl_t;

endpackage

// ----- rtl/gravity_vector_tracking_filter.sv -----
// ----------------------------------------------------------------------------
// gravity_vector_tracking_filter
// Tracks the gravity vector from IMU samples: gyro rotation by a small-angle
// quaternion followed by an accelerometer correction, in saturating fixed
// point.
// ----------------------------------------------------------------------------
// The block takes one sample word at a time. The first sample after reset
// loads the estimate from the accelerometer through the load and write
// steps; every later sample runs a filter update through the half-angle,
// cross product, correction and write steps, and the next sample is taken
// once the sequencer is idle again. It steps three axis lanes, each
// with two product registers, through the half-angle, both cross products and
// the correction, one multiply or one round-and-saturate step per cycle. The
// result sits in an output register, so a new sample is accepted while the
// previous result is stalled; a finished update waits only if the output
// register is still full. Configuration words are taken in any cycle and
// should be written while the block is idle. Each result carries the estimate
// in signed Q(31-F).F accelerometer counts, F = GRAVITY_FRAC_BITS.
module gravity_vector_tracking_filter #(
    parameter int GRAVITY_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  gvtf_pkg::sample_word_t              sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output gvtf_pkg::result_word_t              result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gvtf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gvtf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HALF_MUL,
        S_HALF_SUM,
        S_CROSS1_MUL,
        S_T_SUM,
        S_CROSS2_MUL,
        S_D_SUM,
        S_CORR_MUL,
        S_CORR_SUM,
        S_LOAD,
        S_WRITE
    } state_t;

    state_t                          state_reg, state_next;
    logic                            primed_reg, primed_next;
    gvtf_pkg::g_vec_t                grav_reg, grav_next;
    gvtf_pkg::sample_word_t          sample_reg, sample_next;
    gvtf_pkg::result_word_t          result_reg, result_next;
    logic                            result_valid_reg, result_valid_next;
    logic [gvtf_pkg::GAIN_W-1:0]     gain_reg, gain_next;
    logic [gvtf_pkg::SCALE_W-1:0]    scale_reg, scale_next;

    gvtf_pkg::lane_ctrl_t            lane_ctrl;
    gvtf_pkg::r_vec_t                r_vec;
    gvtf_pkg::g_vec_t                res_vec;
    logic signed [15:0]              acc_lane [3];
    logic signed [15:0]              gyro_lane [3];
    logic                            write_en;

    assign acc_lane[0] = sample_reg.acc_x;
    assign acc_lane[1] = sample_reg.acc_y;
    assign acc_lane[2] = sample_reg.acc_z;
    assign gyro_lane[0] = sample_reg.gyro_x;
    assign gyro_lane[1] = sample_reg.gyro_y;
    assign gyro_lane[2] = sample_reg.gyro_z;

    // Three axis lanes working side by side.
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        gvtf_lane #(
            .LANE      (i),
            .FRAC_BITS (GRAVITY_FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .ctrl    (lane_ctrl),
            .gain    (gain_reg),
            .scale   (scale_reg),
            .acc     (acc_lane[i]),
            .gyro    (gyro_lane[i]),
            .r_vec   (r_vec),
            .g_vec   (grav_reg),
            .res_vec (res_vec),
            .r       (r_vec[i]),
            .res     (res_vec[i])
        );
    end

    // Lane operation for each sequencer step.
    always_comb
    begin
        lane_ctrl.op = gvtf_pkg::OP_IDLE;
        lane_ctrl.src_res = 1'b0;
        case (state_reg)
            S_HALF_MUL:   lane_ctrl.op = gvtf_pkg::OP_HALF_MUL;
            S_HALF_SUM:   lane_ctrl.op = gvtf_pkg::OP_HALF_SUM;
            S_CROSS1_MUL: lane_ctrl.op = gvtf_pkg::OP_CROSS_MUL;
            S_T_SUM:      lane_ctrl.op = gvtf_pkg::OP_T_SUM;
            S_CROSS2_MUL:
            begin
                lane_ctrl.op = gvtf_pkg::OP_CROSS_MUL;
                lane_ctrl.src_res = 1'b1;
            end
            S_D_SUM:      lane_ctrl.op = gvtf_pkg::OP_D_SUM;
            S_CORR_MUL:
            begin
                lane_ctrl.op = gvtf_pkg::OP_CORR_MUL;
                lane_ctrl.src_res = 1'b1;
            end
            S_CORR_SUM:
            begin
                lane_ctrl.op = gvtf_pkg::OP_CORR_SUM;
                lane_ctrl.src_res = 1'b1;
            end
            S_LOAD:       lane_ctrl.op = gvtf_pkg::OP_LOAD;
            default:      lane_ctrl.op = gvtf_pkg::OP_IDLE;
        endcase
    end

    // The merged estimate is written once the output register is free.
    assign write_en = (state_reg == S_WRITE) && (!result_valid_reg || !result_stall);

    // Sequencer, estimate, output register and configuration registers.
    always_comb
    begin
        state_next = state_reg;
        primed_next = primed_reg;
        grav_next = grav_reg;
        sample_next = sample_reg;
        result_next = result_reg;
        result_valid_next = result_valid_reg;
        gain_next = gain_reg;
        scale_next = scale_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    sample_next = sample;
                    state_next = primed_reg ? S_HALF_MUL : S_LOAD;
                end
            end
            S_HALF_MUL:   state_next = S_HALF_SUM;
            S_HALF_SUM:   state_next = S_CROSS1_MUL;
            S_CROSS1_MUL: state_next = S_T_SUM;
            S_T_SUM:      state_next = S_CROSS2_MUL;
            S_CROSS2_MUL: state_next = S_D_SUM;
            S_D_SUM:      state_next = S_CORR_MUL;
            S_CORR_MUL:   state_next = S_CORR_SUM;
            S_CORR_SUM:   state_next = S_WRITE;
            S_LOAD:       state_next = S_WRITE;
            S_WRITE:
            begin
                if (write_en)
                begin
                    grav_next = res_vec;
                    result_next.gravity_x = res_vec[0];
                    result_next.gravity_y = res_vec[1];
                    result_next.gravity_z = res_vec[2];
                    result_next.primed = primed_reg;
                    result_next.last_of_run = 1'b1;
                    result_valid_next = 1'b1;
                    primed_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase

        if (cfg_valid)
        begin
            if (cfg_index == gvtf_pkg::REG_CORRECTION_GAIN)
            begin
                gain_next = cfg_data[gvtf_pkg::GAIN_W-1:0];
            end
            else if (cfg_index == gvtf_pkg::REG_HALF_ANGLE_SCALE)
            begin
                scale_next = cfg_data[gvtf_pkg::SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            primed_reg <= 1'b0;
            grav_reg <= '0;
            sample_reg <= '0;
            result_reg <= '0;
            result_valid_reg <= 1'b0;
            gain_reg <= gvtf_pkg::GAIN_RESET;
            scale_reg <= gvtf_pkg::SCALE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            primed_reg <= primed_next;
            grav_reg <= grav_next;
            sample_reg <= sample_next;
            result_reg <= result_next;
            result_valid_reg <= result_valid_next;
            gain_reg <= gain_next;
            scale_reg <= scale_next;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result = result_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTH
    // A new result word only ever comes out of the write step.
    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_WRITE))
        else $error("result word raised outside the write step");

    // The written word carries the primed flag from before the write.
    a_primed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        write_en |=> result_valid && (result.primed == $past(primed_reg)))
        else $error("result primed flag does not match the filter state");

    // After any write the filter is primed and the stored x and z components match the word.
    a_estimate_kept: assert property (@(posedge clk) disable iff (!rst_n)
        write_en |=> primed_reg && (grav_reg[0] == result.gravity_x)
            && (grav_reg[2] == result.gravity_z))
        else $error("stored estimate differs from the written result");
`endif

endmodule

// ----- rtl/gvtf_lane.sv -----
// ----------------------------------------------------------------------------
// gvtf_lane
// One axis of the filter. Multipliers feed two product registers, followed
// by rounding, accumulation and saturation to 32 bits. The sequencer steps all
// three lanes together through the half-angle, cross product and correction.
// ----------------------------------------------------------------------------
module gvtf_lane #(
    parameter int LANE = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  gvtf_pkg::lane_ctrl_t            ctrl,
    input  logic [gvtf_pkg::GAIN_W-1:0]     gain,
    input  logic [gvtf_pkg::SCALE_W-1:0]    scale,
    input  logic signed [15:0]              acc,
    input  logic signed [15:0]              gyro,
    input  gvtf_pkg::r_vec_t                r_vec,
    input  gvtf_pkg::g_vec_t                g_vec,
    input  gvtf_pkg::g_vec_t                res_vec,
    output gvtf_pkg::r_val_t                r,
    output gvtf_pkg::g_val_t                res
);

    // The other two axes that enter this lane's cross product component.
    localparam int J = (LANE + 1) % 3;
    localparam int K = (LANE + 2) % 3;
    localparam int G_W = gvtf_pkg::G_W;
    localparam int R_W = gvtf_pkg::R_W;
    localparam int R_FRAC = gvtf_pkg::R_FRAC;
    // Error term width and product width.
    localparam int EW = (16 + FRAC_BITS >= 32) ? 17 + FRAC_BITS : 33;
    localparam int PW = (EW + 17 > R_W + G_W) ? EW + 17 : R_W + G_W;
    localparam int SW = PW + 2;
    localparam int HALF_SHIFT = 32 - R_FRAC;
    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (G_W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (G_W - 1));

    logic signed [PW-1:0] p1_reg, p1_next;
    logic signed [PW-1:0] p2_reg, p2_next;
    logic signed [R_W-1:0] r_reg, r_next;
    logic signed [G_W-1:0] res_reg, res_next;

    function automatic logic signed [G_W-1:0] sat(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] y;
        begin
            y = x;
            if (x > SAT_HI)
            begin
                y = SAT_HI;
            end
            else if (x < SAT_LO)
            begin
                y = SAT_LO;
            end
            return y[G_W-1:0];
        end
    endfunction

    // Operand selection, multipliers and the rounding and saturation stage.
    always_comb
    begin
        logic signed [G_W-1:0] b_j;
        logic signed [G_W-1:0] b_k;
        logic signed [G_W-1:0] base;
        logic signed [36:0] half_prod;
        logic signed [PW-1:0] half_rnd;
        logic signed [R_W+G_W-1:0] cross_a;
        logic signed [R_W+G_W-1:0] cross_b;
        logic signed [PW:0] diff;
        logic signed [PW:0] diff_rnd;
        logic signed [PW-R_FRAC:0] cx;
        logic signed [EW-1:0] acc_sc;
        logic signed [EW-1:0] err;
        logic signed [EW+16:0] corr_prod;
        logic signed [PW-1:0] corr_rnd;
        b_j = ctrl.src_res ? res_vec[J] : g_vec[J];
        b_k = ctrl.src_res ? res_vec[K] : g_vec[K];
        base = ctrl.src_res ? res_vec[LANE] : g_vec[LANE];
        half_prod = gyro * $signed({1'b0, scale});
        half_rnd = p1_reg + PW'(1 <<< (HALF_SHIFT - 1));
        cross_a = $signed(r_vec[J]) * b_k;
        cross_b = $signed(r_vec[K]) * b_j;
        diff = (PW + 1)'(p1_reg) - (PW + 1)'(p2_reg);
        diff_rnd = diff + (PW + 1)'(1 <<< (R_FRAC - 1));
        cx = diff_rnd[PW:R_FRAC];
        acc_sc = EW'(acc) <<< FRAC_BITS;
        err = acc_sc - EW'(base);
        corr_prod = err * $signed({1'b0, gain});
        corr_rnd = p1_reg + PW'(1 <<< 15);

        p1_next = p1_reg;
        p2_next = p2_reg;
        r_next = r_reg;
        res_next = res_reg;
        case (ctrl.op)
            gvtf_pkg::OP_HALF_MUL:
            begin
                p1_next = PW'(half_prod);
            end
            gvtf_pkg::OP_HALF_SUM:
            begin
                r_next = half_rnd[R_W+HALF_SHIFT-1:HALF_SHIFT];
            end
            gvtf_pkg::OP_CROSS_MUL:
            begin
                p1_next = PW'(cross_a);
                p2_next = PW'(cross_b);
            end
            gvtf_pkg::OP_T_SUM:
            begin
                res_next = sat(SW'(cx) + SW'(base));
            end
            gvtf_pkg::OP_D_SUM:
            begin
                res_next = sat(SW'(base) + (SW'(cx) <<< 1));
            end
            gvtf_pkg::OP_CORR_MUL:
            begin
                p1_next = PW'(corr_prod);
            end
            gvtf_pkg::OP_CORR_SUM:
            begin
                res_next = sat(SW'($signed(corr_rnd[PW-1:16])) + SW'(base));
            end
            gvtf_pkg::OP_LOAD:
            begin
                res_next = sat(SW'(acc_sc));
            end
            default:
            begin
                p1_next = p1_reg;
            end
        endcase
    end

    // Products and lane results are plain data registers.
    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        r_reg <= r_next;
        res_reg <= res_next;
    end

    assign r = r_reg;
    assign res = res_reg;

endmodule
